>>> hdl/packet_to_chunk_segmenter_assert.svh
// Assertion macros shared by the segmenter modules.
`ifndef PACKET_TO_CHUNK_SEGMENTER_ASSERT_SVH
`define PACKET_TO_CHUNK_SEGMENTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define P2CS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define P2CS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/p2cs_pkg.sv
package p2cs_pkg;

    localparam int LENGTH_W       = 16;
    localparam int LIMIT_W        = 10;
    localparam int CHUNK_W        = 32;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 80;
    localparam int OUT_TUSER_W    = 3;

    localparam int HEADER_BYTES_DEFAULT = 4;
    localparam int MAX_RESULTS          = 64;
    localparam int COUNT_W              = $clog2(MAX_RESULTS);

    localparam logic [LENGTH_W-1:0] PAYLOAD_BYTES_RESET = 16'd4072;
    localparam logic [LIMIT_W-1:0]  PACKET_LIMIT_RESET  = 10'd1023;

    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_BYTES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_LIMIT  = 8'd1;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

>>> hdl/p2cs_ctrl.sv
`include "packet_to_chunk_segmenter_assert.svh"

module p2cs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output p2cs_pkg::cmd_t    cmd,
    input  p2cs_pkg::status_t status
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = (state_reg == ST_RUN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.step && status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = cmd.step || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `P2CS_ASSERT_SAME(a_no_step_when_idle, clk, rst_n, state_reg == ST_IDLE, !cmd.step, "Fragment step while idle")
    `P2CS_ASSERT_NEXT(a_idle_after_done, clk, rst_n, cmd.step && status.done, state_reg == ST_IDLE, "Not idle after last fragment")
    `P2CS_ASSERT_NEXT(a_valid_after_step, clk, rst_n, cmd.step, m_tvalid_reg, "Fragment result not presented")

endmodule

>>> hdl/p2cs_datapath.sv
`include "packet_to_chunk_segmenter_assert.svh"

module p2cs_datapath
#(
    parameter int HEADER_BYTES = p2cs_pkg::HEADER_BYTES_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [p2cs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    output logic [p2cs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [p2cs_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    input  logic [p2cs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [p2cs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  p2cs_pkg::cmd_t                       cmd,
    output p2cs_pkg::status_t                    status
);

    localparam int LW = p2cs_pkg::LENGTH_W;
    localparam int PW = p2cs_pkg::LIMIT_W;
    localparam int CW = p2cs_pkg::CHUNK_W;
    localparam int NW = p2cs_pkg::COUNT_W;

    logic [LW-1:0] payload_reg;
    logic [PW-1:0] limit_reg;
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;
    logic [PW-1:0] held_reg;
    logic [PW-1:0] held_next;
    logic [CW-1:0] chunk_reg;
    logic [CW-1:0] chunk_next;
    logic          carry_reg;
    logic          carry_next;
    logic [LW-1:0] remaining_reg;
    logic [LW-1:0] remaining_next;
    logic          eod_reg;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    logic [CW-1:0] out_chunk_reg;
    logic [LW-1:0] out_offset_reg;
    logic [LW-1:0] out_frag_reg;
    logic [PW-1:0] out_packets_reg;
    logic          out_closed_reg;
    logic          out_starts_reg;
    logic          out_ends_reg;
    logic          out_last_reg;

    logic [LW:0]   used;
    logic [LW:0]   room_diff;
    logic          room_pos;
    logic [LW-1:0] room;
    logic          fits;
    logic [LW-1:0] frag;
    logic [LW:0]   fill_sum;
    logic [LW-1:0] fill_sat;
    logic [LW:0]   fill_end;
    logic          last_slot;
    logic          cont;
    logic [PW-1:0] held_inc;
    logic          closed;

    assign used      = {1'b0, fill_reg} + (LW+1)'(HEADER_BYTES);
    assign room_diff = {1'b0, payload_reg} - used;
    assign room_pos  = ({1'b0, payload_reg} > used);
    assign room      = room_pos ? room_diff[LW-1:0] : '0;
    assign fits      = (remaining_reg < room);
    assign frag      = fits ? remaining_reg : room;
    assign fill_sum  = used + {1'b0, frag};
    assign fill_sat  = fill_sum[LW] ? '1 : fill_sum[LW-1:0];
    assign fill_end  = {1'b0, fill_sat} + (LW+1)'(HEADER_BYTES);
    assign last_slot = (count_reg == NW'(p2cs_pkg::MAX_RESULTS - 1));
    assign cont      = !fits && (remaining_reg != room) && !last_slot;
    assign held_inc  = held_reg + PW'(1);

    assign closed = (fill_end >= {1'b0, payload_reg}) || (held_inc >= limit_reg) ||
                    (!cont && eod_reg);

    assign status.done = !cont;

    always_comb
    begin
        fill_next      = fill_reg;
        held_next      = held_reg;
        chunk_next     = chunk_reg;
        carry_next     = carry_reg;
        remaining_next = remaining_reg;
        count_next     = count_reg;
        if (cmd.load)
        begin
            remaining_next = s_tdata[LW-1:0];
            count_next     = '0;
        end
        else if (cmd.step)
        begin
            remaining_next = remaining_reg - frag;
            count_next     = count_reg + NW'(1);
            if (closed)
            begin
                fill_next  = '0;
                held_next  = '0;
                chunk_next = chunk_reg + CW'(1);
                carry_next = cont;
            end
            else
            begin
                fill_next = fill_sat;
                held_next = held_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg <= p2cs_pkg::PAYLOAD_BYTES_RESET;
            limit_reg   <= p2cs_pkg::PACKET_LIMIT_RESET;
            fill_reg    <= '0;
            held_reg    <= '0;
            chunk_reg   <= '0;
            carry_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == p2cs_pkg::REG_PAYLOAD_BYTES))
            begin
                payload_reg <= cfg_data[LW-1:0];
            end
            if (cfg_valid && (cfg_index == p2cs_pkg::REG_PACKET_LIMIT))
            begin
                limit_reg <= cfg_data[PW-1:0];
            end
            fill_reg  <= fill_next;
            held_reg  <= held_next;
            chunk_reg <= chunk_next;
            carry_reg <= carry_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        if (cmd.load)
        begin
            eod_reg <= s_tlast;
        end
        if (cmd.step)
        begin
            out_chunk_reg   <= chunk_reg;
            out_offset_reg  <= fill_reg;
            out_frag_reg    <= frag;
            out_packets_reg <= held_inc;
            out_closed_reg  <= closed;
            out_starts_reg  <= carry_reg;
            out_ends_reg    <= closed && cont;
            out_last_reg    <= !cont;
        end
    end

    assign m_tdata = {6'b0, out_packets_reg, out_frag_reg, out_offset_reg, out_chunk_reg};
    assign m_tuser = {out_ends_reg, out_starts_reg, out_closed_reg};
    assign m_tlast = out_last_reg;

    `P2CS_ASSERT_NEXT(a_count_cleared_on_load, clk, rst_n, cmd.load, count_reg == '0, "Fragment count not cleared")
    `P2CS_ASSERT_NEXT(a_ends_implies_closed, clk, rst_n, cmd.step, !out_ends_reg || out_closed_reg, "Continued end on open chunk")
    `P2CS_ASSERT_NEXT(a_close_resets_fill, clk, rst_n, cmd.step && closed, fill_reg == '0 && held_reg == '0, "Closed chunk not reset")

endmodule

>>> hdl/packet_to_chunk_segmenter.sv
// Packet to chunk segmenter. Each transfer on the slave side carries one packet length and
// is cut into fragments, each a HEADER_BYTES header plus as much of the packet as the open
// chunk still holds; one transfer leaves the master side per fragment, with the chunk number,
// header offset, fragment length, chunk packet count and the close and continuation flags. A
// packet is first accepted and its fragments then pass one by one through the single fragment
// unit, which holds whenever the master side stalls; the next packet is taken only after the
// last fragment of the current one has been registered. At most 64 fragments are produced per
// packet. Configuration writes are accepted at any time but must only be issued while the
// block is idle.
module packet_to_chunk_segmenter
#(
    parameter int HEADER_BYTES = p2cs_pkg::HEADER_BYTES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] packet_length
    input  logic [p2cs_pkg::IN_TDATA_W-1:0]   s_tdata,
    // end_of_data
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] chunk_number, [47:32] header_offset, [63:48] fragment_length,
    // [73:64] chunk_packets, [79:74] zero
    output logic [p2cs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [0] chunk_closed, [1] starts_continued, [2] ends_continued
    output logic [p2cs_pkg::OUT_TUSER_W-1:0]  m_tuser,
    // last_fragment
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [p2cs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [p2cs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    p2cs_pkg::cmd_t    cmd;
    p2cs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    p2cs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    p2cs_datapath
    #(
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
